FILE: rtl/sed_pkg.sv
// shared types, codes and reset values of the speech endpoint detector
package sed_pkg;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned PROD_W = 2 * CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// request codes
	typedef enum logic [2:0] {
		REQ_FRAME   = 3'd0,
		REQ_ARM     = 3'd1,
		REQ_DISARM  = 3'd2,
		REQ_CANCEL  = 3'd3,
		REQ_OVERRUN = 3'd4
	} req_t;

	// event codes
	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_START   = 3'd1,
		EV_END     = 3'd2,
		EV_TIMEOUT = 3'd3,
		EV_MAXLEN  = 3'd4,
		EV_CANCEL  = 3'd5,
		EV_OVERRUN = 3'd6
	} event_t;

	// turn phase, one-hot
	typedef enum logic [5:0] {
		PH_DISARMED = 6'b000001,
		PH_ARMED    = 6'b000010,
		PH_STARTING = 6'b000100,
		PH_SPEECH   = 6'b001000,
		PH_HANGOVER = 6'b010000,
		PH_COMPLETE = 6'b100000
	} phase_t;

	// reported phase numbers
	localparam logic [2:0] PC_DISARMED = 3'd0;
	localparam logic [2:0] PC_ARMED    = 3'd1;
	localparam logic [2:0] PC_STARTING = 3'd2;
	localparam logic [2:0] PC_SPEECH   = 3'd3;
	localparam logic [2:0] PC_HANGOVER = 3'd4;
	localparam logic [2:0] PC_COMPLETE = 3'd5;

	// register indexes
	localparam logic [2:0] CFG_FRAME_LEN = 3'd0;
	localparam logic [2:0] CFG_START     = 3'd1;
	localparam logic [2:0] CFG_END_SIL   = 3'd2;
	localparam logic [2:0] CFG_TIMEOUT   = 3'd3;
	localparam logic [2:0] CFG_MAX_UTT   = 3'd4;

	// register reset values
	localparam logic [CNT_W-1:0] RST_FRAME_LEN = 16'd20;
	localparam logic [CNT_W-1:0] RST_START     = 16'd60;
	localparam logic [CNT_W-1:0] RST_END_SIL   = 16'd100;
	localparam logic [CNT_W-1:0] RST_TIMEOUT   = 16'd200;
	localparam logic [CNT_W-1:0] RST_MAX_UTT   = 16'd300;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_DISARMED: code = PC_DISARMED;
			PH_ARMED:    code = PC_ARMED;
			PH_STARTING: code = PC_STARTING;
			PH_SPEECH:   code = PC_SPEECH;
			PH_HANGOVER: code = PC_HANGOVER;
			PH_COMPLETE: code = PC_COMPLETE;
			default:     code = PC_DISARMED;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/sed_limit_check.sv
// saturating counter step and frame limit compare against a millisecond setting
module sed_limit_check import sed_pkg::*; (
	input  logic [CNT_W-1:0] count,
	input  logic [CNT_W-1:0] frame_len,
	input  logic [CNT_W-1:0] limit_ms,
	output logic [CNT_W-1:0] count_inc,
	output logic             met
);

	logic [PROD_W-1:0] elapsed_ms;

	// count_inc >= ceil(ms / f) is the same as count_inc * f >= ms for f of at least one
	assign count_inc  = (count == CNT_MAX) ? count : count + 1'b1;
	assign elapsed_ms = PROD_W'(count_inc) * PROD_W'(frame_len);
	assign met        = elapsed_ms >= PROD_W'(limit_ms);

endmodule

FILE: rtl/speech_endpoint_detector.sv
// speech endpoint detector: top level with turn state, limits and result register
//
// follows one spoken turn from per-frame voice activity flags. each request word
// (frame, arm, disarm, cancel, overrun) gives exactly one result word carrying the
// event, the phase after the request and the turn number. a request is taken in
// every cycle; its result appears in the cycle after acceptance in a single output
// register, so the rate is one word per cycle. the input stalls only while that
// output register is full and its consumer stalls. every limit is compared as
// count * frame length >= setting, which equals the frame threshold ceil(setting /
// frame length); a frame length of zero counts as one.
// configuration writes are always ready and act from the next cycle on.
module speech_endpoint_detector import sed_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       req_type,
	input  logic             speech_flag,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output logic [2:0]       event_code,
	output logic [2:0]       phase_now,
	output logic [CNT_W-1:0] turn_number,
	// configuration channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [CNT_W-1:0] cfg_data
);

	// configuration registers
	logic [CNT_W-1:0] frame_len_q;
	logic [CNT_W-1:0] start_ms_q;
	logic [CNT_W-1:0] end_sil_ms_q;
	logic [CNT_W-1:0] timeout_ms_q;
	logic [CNT_W-1:0] max_utt_ms_q;

	// turn state
	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] armed_q, armed_d;
	logic [CNT_W-1:0] cand_q, cand_d;
	logic [CNT_W-1:0] utt_q, utt_d;
	logic [CNT_W-1:0] sil_q, sil_d;
	logic [CNT_W-1:0] serial_q, serial_d;
	event_t           ev_d;

	// result register
	logic             out_valid_q;
	event_t           event_q;
	logic [2:0]       phase_code_q;
	logic [CNT_W-1:0] turn_q;

	// limit checks
	logic [CNT_W-1:0] armed_inc, cand_inc, utt_inc, sil_inc;
	logic             timeout_met, start_met, maxlen_met, end_met;

	logic in_fire;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign in_fire   = in_valid & ~in_stall;

	// zero frame length is stored as one so the limit compare needs no special case
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q  <= RST_FRAME_LEN;
			start_ms_q   <= RST_START;
			end_sil_ms_q <= RST_END_SIL;
			timeout_ms_q <= RST_TIMEOUT;
			max_utt_ms_q <= RST_MAX_UTT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_LEN: frame_len_q  <= (cfg_data == '0) ? CNT_W'(1) : cfg_data;
				CFG_START:     start_ms_q   <= cfg_data;
				CFG_END_SIL:   end_sil_ms_q <= cfg_data;
				CFG_TIMEOUT:   timeout_ms_q <= cfg_data;
				CFG_MAX_UTT:   max_utt_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sed_limit_check u_timeout (
		.count     (armed_q),
		.frame_len (frame_len_q),
		.limit_ms  (timeout_ms_q),
		.count_inc (armed_inc),
		.met       (timeout_met)
	);

	sed_limit_check u_start (
		.count     (cand_q),
		.frame_len (frame_len_q),
		.limit_ms  (start_ms_q),
		.count_inc (cand_inc),
		.met       (start_met)
	);

	sed_limit_check u_maxlen (
		.count     (utt_q),
		.frame_len (frame_len_q),
		.limit_ms  (max_utt_ms_q),
		.count_inc (utt_inc),
		.met       (maxlen_met)
	);

	sed_limit_check u_end (
		.count     (sil_q),
		.frame_len (frame_len_q),
		.limit_ms  (end_sil_ms_q),
		.count_inc (sil_inc),
		.met       (end_met)
	);

	// next turn state for the request word on the input
	always_comb begin
		phase_d  = phase_q;
		armed_d  = armed_q;
		cand_d   = cand_q;
		utt_d    = utt_q;
		sil_d    = sil_q;
		serial_d = serial_q;
		ev_d     = EV_NONE;
		unique case (req_type)
			REQ_FRAME: begin
				if (phase_q == PH_ARMED || phase_q == PH_STARTING) begin
					// waiting for a confirmed start
					armed_d = armed_inc;
					if (speech_flag && start_met) begin
						serial_d = serial_q + 1'b1;
						cand_d   = cand_inc;
						utt_d    = cand_inc;
						sil_d    = '0;
						phase_d  = PH_SPEECH;
						ev_d     = EV_START;
					end else begin
						if (speech_flag) begin
							cand_d  = cand_inc;
							phase_d = PH_STARTING;
						end else begin
							cand_d  = '0;
							phase_d = PH_ARMED;
						end
						if (timeout_met) begin
							phase_d = PH_COMPLETE;
							ev_d    = EV_TIMEOUT;
						end
					end
				end else if (phase_q == PH_SPEECH || phase_q == PH_HANGOVER) begin
					// inside an utterance: length limit first, then hangover
					utt_d = utt_inc;
					if (maxlen_met) begin
						phase_d = PH_COMPLETE;
						ev_d    = EV_MAXLEN;
					end else if (speech_flag) begin
						sil_d   = '0;
						phase_d = PH_SPEECH;
					end else begin
						sil_d = sil_inc;
						if (end_met) begin
							phase_d = PH_COMPLETE;
							ev_d    = EV_END;
						end else begin
							phase_d = PH_HANGOVER;
						end
					end
				end
			end
			REQ_ARM, REQ_DISARM: begin
				armed_d = '0;
				cand_d  = '0;
				utt_d   = '0;
				sil_d   = '0;
				phase_d = (req_type == REQ_ARM) ? PH_ARMED : PH_DISARMED;
			end
			REQ_CANCEL, REQ_OVERRUN: begin
				// aborts only touch an active turn
				if (phase_q != PH_DISARMED && phase_q != PH_COMPLETE) begin
					phase_d = PH_COMPLETE;
					ev_d    = (req_type == REQ_CANCEL) ? EV_CANCEL : EV_OVERRUN;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DISARMED;
			armed_q  <= '0;
			cand_q   <= '0;
			utt_q    <= '0;
			sil_q    <= '0;
			serial_q <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			armed_q  <= armed_d;
			cand_q   <= cand_d;
			utt_q    <= utt_d;
			sil_q    <= sil_d;
			serial_q <= serial_d;
		end
	end

	// result register: valid is control, the payload needs no reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			event_q      <= ev_d;
			phase_code_q <= phase_code(phase_d);
			turn_q       <= serial_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_code  = event_q;
	assign phase_now   = phase_code_q;
	assign turn_number = turn_q;

endmodule
